// ----- hdl/fbcr_pkg.sv -----
`default_nettype none
package fbcr_pkg;

   // Kinds of input word.
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Read map.
   localparam logic [3:0] RD_WIDTH   = 4'd0;
   localparam logic [3:0] RD_HEIGHT  = 4'd1;
   localparam logic [3:0] RD_STATUS  = 4'd2;
   localparam logic [3:0] RD_PHYS_W  = 4'd7;
   localparam logic [3:0] RD_PHYS_H  = 4'd8;
   localparam logic [3:0] RD_FORMAT  = 4'd9;

   // Write map.
   localparam logic [3:0] WR_IRQ_EN  = 4'd3;
   localparam logic [3:0] WR_BASE    = 4'd4;
   localparam logic [3:0] WR_ROTATE  = 4'd5;
   localparam logic [3:0] WR_BLANK   = 4'd6;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DPI    = 2'd2;
   localparam logic [1:0] CSR_FORMAT = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [11:0] RESET_WIDTH  = 12'd320;
   localparam logic [11:0] RESET_HEIGHT = 12'd480;
   localparam logic [9:0]  RESET_DPI    = 10'd165;
   localparam logic [2:0]  RESET_FORMAT = 3'd4;

   // Interrupt status bits.
   localparam int INT_VSYNC     = 0;
   localparam int INT_BASE_DONE = 1;

   // Millimetre divider: numerator 254*pixels + 5*dpi fits in 21 bits,
   // divisor 10*dpi in 14 bits.
   localparam int NUM_W     = 21;
   localparam int DIVISOR_W = 14;
   localparam int DIV_STEPS = NUM_W;
   localparam int COUNT_W   = 5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic        bad_offset;
      logic        resize_request;
      logic        full_refresh;
      logic        display_active;
      logic        blank_state;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic update;     // accept a word handled at once; load response
      logic start_div;  // accept a millimetre read; load the divider
      logic step_div;   // one quotient bit
      logic load_mm;    // load the millimetre response
   } cmd_type;

   typedef struct packed {
      logic is_mm;      // waiting word is a millimetre read
      logic div_last;   // this step yields the final quotient bit
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/fbcr_ctrl.sv -----
`default_nettype none
module fbcr_ctrl
   import fbcr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The response register may be reloaded when empty or being emptied.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && slot_free && status.is_mm) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.update    = 1'b0;
      cmd.start_div = 1'b0;
      cmd.step_div  = 1'b0;
      cmd.load_mm   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = slot_free;
            cmd.update    = req_valid && slot_free && !status.is_mm;
            cmd.start_div = req_valid && slot_free && status.is_mm;
         end
         ST_DIVIDE: begin
            cmd.step_div = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_mm = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update || cmd.load_mm) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- hdl/fbcr_datapath.sv -----
`default_nettype none
module fbcr_datapath
   import fbcr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire req_type                req_data,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire cmd_type                cmd,
   output status_type                  status,
   output rsp_type                     rsp_data
);

   // Configuration.
   logic [11:0] width_ff, height_ff;
   logic [9:0]  dpi_ff;
   logic [2:0]  format_ff;

   // Register file state.
   logic [31:0] base_address_ff, base_address_in;
   logic        base_seen_ff, base_seen_in;
   logic        refresh_pending_ff, refresh_pending_in;
   logic        base_irq_armed_ff, base_irq_armed_in;
   logic [1:0]  pending_rotation_ff, pending_rotation_in;
   logic [1:0]  active_rotation_ff, active_rotation_in;
   logic        blanked_ff, blanked_in;
   logic [1:0]  irq_status_ff, irq_status_in;
   logic [1:0]  irq_enable_ff, irq_enable_in;
   logic        irq_line_ff, irq_line_in;

   // Divider.
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DIVISOR_W:0]   trial;
   logic [11:0]          pixels;
   logic [9:0]           dpi_eff;

   rsp_type rsp_ff, rsp_in, direct_rsp;
   logic [1:0] status_read;
   logic [1:0] status_after_base;

   assign status.is_mm = (req_data.kind == KIND_READ)
                         && ((req_data.reg_index == RD_PHYS_W)
                             || (req_data.reg_index == RD_PHYS_H));
   assign status.div_last = (count_ff == COUNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         dpi_ff    <= RESET_DPI;
         format_ff <= RESET_FORMAT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data[11:0];
            CSR_HEIGHT: height_ff <= csr_data[11:0];
            CSR_DPI:    dpi_ff    <= csr_data[9:0];
            CSR_FORMAT: format_ff <= csr_data[2:0];
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // Behaviour of reads, writes and ticks other than millimetre reads.
   always_comb begin
      base_address_in     = base_address_ff;
      base_seen_in        = base_seen_ff;
      refresh_pending_in  = refresh_pending_ff;
      base_irq_armed_in   = base_irq_armed_ff;
      pending_rotation_in = pending_rotation_ff;
      active_rotation_in  = active_rotation_ff;
      blanked_in          = blanked_ff;
      irq_status_in       = irq_status_ff;
      irq_enable_in       = irq_enable_ff;
      irq_line_in         = irq_line_ff;
      direct_rsp          = '0;
      status_read         = irq_status_ff & irq_enable_ff;
      status_after_base   = irq_status_ff;
      status_after_base[INT_BASE_DONE] = 1'b0;

      unique case (req_data.kind)
         KIND_READ: begin
            unique case (req_data.reg_index)
               RD_WIDTH:  direct_rsp.read_data = {20'd0, width_ff};
               RD_HEIGHT: direct_rsp.read_data = {20'd0, height_ff};
               RD_FORMAT: direct_rsp.read_data = {29'd0, format_ff};
               RD_PHYS_W, RD_PHYS_H: direct_rsp.read_data = '0;
               RD_STATUS: begin
                  direct_rsp.read_data = {30'd0, status_read};
                  if (status_read != 2'b00) begin
                     irq_status_in = irq_status_ff & ~status_read;
                     irq_line_in   = 1'b0;
                  end
               end
               default: direct_rsp.bad_offset = 1'b1;
            endcase
         end
         KIND_WRITE: begin
            unique case (req_data.reg_index)
               WR_IRQ_EN: begin
                  irq_enable_in = req_data.write_data[1:0];
                  irq_line_in   = |(irq_status_ff & req_data.write_data[1:0]);
               end
               WR_BASE: begin
                  direct_rsp.resize_request = !base_seen_ff;
                  base_address_in    = req_data.write_data;
                  irq_status_in      = status_after_base;
                  refresh_pending_in = 1'b1;
                  base_irq_armed_in  = 1'b1;
                  base_seen_in       = 1'b1;
                  if (pending_rotation_ff != active_rotation_ff) begin
                     active_rotation_in        = pending_rotation_ff;
                     direct_rsp.resize_request = 1'b1;
                  end
                  irq_line_in = |(status_after_base & irq_enable_ff);
               end
               WR_ROTATE: pending_rotation_in = req_data.write_data[1:0];
               WR_BLANK: begin
                  blanked_in         = req_data.write_data[0];
                  refresh_pending_in = 1'b1;
               end
               default: direct_rsp.bad_offset = 1'b1;
            endcase
         end
         KIND_TICK: begin
            if (base_address_ff != 32'd0) begin
               direct_rsp.display_active = 1'b1;
               if (irq_enable_ff[INT_VSYNC] && !irq_status_ff[INT_VSYNC]) begin
                  irq_status_in[INT_VSYNC] = 1'b1;
                  irq_line_in              = 1'b1;
               end
               if (refresh_pending_ff) begin
                  direct_rsp.full_refresh = 1'b1;
                  if (base_irq_armed_ff) begin
                     irq_status_in[INT_BASE_DONE] = 1'b1;
                     if (irq_enable_ff[INT_BASE_DONE]) begin
                        irq_line_in = 1'b1;
                     end
                  end
                  base_irq_armed_in  = 1'b0;
                  refresh_pending_in = 1'b0;
               end
            end
         end
         default: direct_rsp.read_data = '0;
      endcase

      direct_rsp.irq_level   = irq_line_in;
      direct_rsp.blank_state = blanked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff     <= '0;
         base_seen_ff        <= 1'b0;
         refresh_pending_ff  <= 1'b0;
         base_irq_armed_ff   <= 1'b0;
         pending_rotation_ff <= '0;
         active_rotation_ff  <= '0;
         blanked_ff          <= 1'b0;
         irq_status_ff       <= '0;
         irq_enable_ff       <= '0;
         irq_line_ff         <= 1'b0;
      end else if (cmd.update) begin
         base_address_ff     <= base_address_in;
         base_seen_ff        <= base_seen_in;
         refresh_pending_ff  <= refresh_pending_in;
         base_irq_armed_ff   <= base_irq_armed_in;
         pending_rotation_ff <= pending_rotation_in;
         active_rotation_ff  <= active_rotation_in;
         blanked_ff          <= blanked_in;
         irq_status_ff       <= irq_status_in;
         irq_enable_ff       <= irq_enable_in;
         irq_line_ff         <= irq_line_in;
      end
   end

   // Restoring divider, one quotient bit per cycle. The quotient shifts
   // into the numerator register as the numerator shifts out.
   assign pixels  = (req_data.reg_index == RD_PHYS_W) ? width_ff : height_ff;
   assign dpi_eff = (dpi_ff == 10'd0) ? 10'd1 : dpi_ff;
   assign trial   = {rem_ff, num_ff[NUM_W-1]};

   always_comb begin
      num_in     = num_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      if (cmd.start_div) begin
         num_in     = (NUM_W'(pixels) * NUM_W'(254)) + (NUM_W'(dpi_eff) * NUM_W'(5));
         divisor_in = DIVISOR_W'(dpi_eff) * DIVISOR_W'(10);
         rem_in     = '0;
         count_in   = '0;
      end else if (cmd.step_div) begin
         count_in = count_ff + COUNT_W'(1);
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, divisor_ff});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      count_ff   <= count_in;
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.update) begin
         rsp_in = direct_rsp;
      end else if (cmd.load_mm) begin
         rsp_in             = '0;
         rsp_in.read_data   = 32'(num_ff);
         rsp_in.irq_level   = irq_line_ff;
         rsp_in.blank_state = blanked_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- hdl/framebuffer_control_registers.sv -----
// A word other than a millimetre read gives its response in the cycle
// after acceptance; a millimetre read passes the 21-step bit-serial
// divider, then loads its response once the response slot is free.
// Ordinary words: one per cycle while responses drain; none during a
// millimetre read. Synchronous active-high reset clears register file
// state and loads configuration defaults (320x480, 165 dpi, format 4).
`default_nettype none
module framebuffer_control_registers
   import fbcr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   // Configuration words are taken at any time.
   assign csr_ready = 1'b1;

   fbcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fbcr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
